// File: sv/mbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared constants, types and helper functions of the mip box downsampler.
// ----------------------------------------------------------------------------
package mbd_pkg;

   localparam int MAX_WIDTH    = 4096;
   localparam int MAX_LEVELS   = 12;
   localparam int MAX_CHANNELS = 4;

   localparam int ADDR_W = $clog2(MAX_WIDTH);      // pair-sum store address
   localparam int POS_W  = $clog2(MAX_WIDTH);      // column / row counter
   localparam int DIM_W  = $clog2(MAX_WIDTH) + 1;  // level dimension
   localparam int LEV_W  = 4;
   localparam int NCH_W  = 3;
   localparam int CH_W   = 8;
   localparam int HS_W   = CH_W + 1;               // sum of two channel values
   localparam int TOT_W  = CH_W + 2;               // sum of four channel values
   localparam int OPOS_W = 11;
   localparam int ROUND  = 2;                      // rounding bias before >> 2
   localparam int DATA_W = 32;
   localparam int PADDR_W = 4;

   localparam logic [1:0] REG_WIDTH    = 2'd0;
   localparam logic [1:0] REG_HEIGHT   = 2'd1;
   localparam logic [1:0] REG_LEVELS   = 2'd2;
   localparam logic [1:0] REG_CHANNELS = 2'd3;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_LEVEL,
      SEQ_SUM
   } seq_state_type;

   typedef logic [MAX_CHANNELS-1:0][CH_W-1:0] pixel_type;
   typedef logic [MAX_CHANNELS-1:0][HS_W-1:0] pair_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;    // clamped level-0 width
      logic [DIM_W-1:0] height;   // clamped level-0 height
      logic [LEV_W-1:0] levels;   // clamped level count
      logic [NCH_W-1:0] channels; // clamped channel count
      logic             restart;  // register write: restart the frame
   } cfg_type;

   typedef struct packed {
      logic [LEV_W-1:0]  level;
      logic [OPOS_W-1:0] x;
      logic [OPOS_W-1:0] y;
      pixel_type         chan;
   } result_type;

   // Dimension of a level: halve and floor per level, never below 1.
   function automatic logic [DIM_W-1:0] dim_at(input logic [DIM_W-1:0] d0,
                                               input logic [LEV_W-1:0] lev);
      logic [DIM_W-1:0] s;
      begin
         s = d0 >> lev;
         return (s == '0) ? DIM_W'(1) : s;
      end
   endfunction

   // Rounded mean of four values from their sum.
   function automatic logic [CH_W-1:0] box_mean(input logic [TOT_W-1:0] tot);
      logic [TOT_W:0] s;
      begin
         s = {1'b0, tot} + (TOT_W + 1)'(ROUND);
         return s[CH_W+1:2];
      end
   endfunction

endpackage

// File: sv/mbd_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_req_if
// Input pixel channel: valid/ready with four channel values.
// ----------------------------------------------------------------------------
interface mbd_req_if;
   logic                     valid;
   logic                     ready;
   logic [mbd_pkg::CH_W-1:0] chan_0;
   logic [mbd_pkg::CH_W-1:0] chan_1;
   logic [mbd_pkg::CH_W-1:0] chan_2;
   logic [mbd_pkg::CH_W-1:0] chan_3;

   modport source (output valid, output chan_0, output chan_1, output chan_2,
                   output chan_3, input ready);
   modport sink   (input valid, input chan_0, input chan_1, input chan_2,
                   input chan_3, output ready);
endinterface

// File: sv/mbd_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_rsp_if
// Result channel: valid/ready with one mip pixel, its level and position.
// ----------------------------------------------------------------------------
interface mbd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [mbd_pkg::LEV_W-1:0]  out_level;
   logic [mbd_pkg::OPOS_W-1:0] out_x;
   logic [mbd_pkg::OPOS_W-1:0] out_y;
   logic [mbd_pkg::CH_W-1:0]   out_chan_0;
   logic [mbd_pkg::CH_W-1:0]   out_chan_1;
   logic [mbd_pkg::CH_W-1:0]   out_chan_2;
   logic [mbd_pkg::CH_W-1:0]   out_chan_3;
   logic                       last_of_run;

   modport source (output valid, output out_level, output out_x, output out_y,
                   output out_chan_0, output out_chan_1, output out_chan_2,
                   output out_chan_3, output last_of_run, input ready);
   modport sink   (input valid, input out_level, input out_x, input out_y,
                   input out_chan_0, input out_chan_1, input out_chan_2,
                   input out_chan_3, input last_of_run, output ready);
endinterface

// File: sv/mipmap_box_downsampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipmap_box_downsampler
// Streams level-0 pixels in raster order and emits the 2x2 box-filtered
// pixels of up to twelve mip levels below it.
// ----------------------------------------------------------------------------
// Each accepted item is walked through the level cascade by a sequencer that
// handles one level per cycle while the result stage can move: level 1 takes
// the input pixel, and every completed pixel feeds the next level. Horizontal
// pairs wait in a small per-level pending register; vertical pairs go through
// one shared 4096 x 36 single-port pair-sum memory (even rows write, odd rows
// read back) whose registered read adds a read-back state to every level that
// closes a 2x2 block on an odd row. An item whose last configured level
// produces a pixel also takes a closing step for the level past it. The next
// item is taken in the same cycle the previous one retires. Results leave
// through a one-deep hold stage plus an output register, so last_of_run is
// set on the final result of each item. Any register write restarts the
// frame; write registers only while no item is in flight.
// ----------------------------------------------------------------------------
module mipmap_box_downsampler (
   input  logic                         clock,
   input  logic                         reset,
   mbd_req_if.sink                      req_chan,
   mbd_rsp_if.source                    rsp_chan,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [mbd_pkg::PADDR_W-1:0] paddr,
   input  logic [mbd_pkg::DATA_W-1:0]  pwdata,
   output logic [mbd_pkg::DATA_W-1:0]  prdata,
   output logic                         pready
);

   mbd_pkg::cfg_type cfg;

   mbd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // ------------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------------
   mbd_pkg::seq_state_type state_ff, state_in;

   logic [mbd_pkg::LEV_W-1:0]  lev_ff;
   logic [mbd_pkg::ADDR_W-1:0] base_ff;
   mbd_pkg::pixel_type         px_ff;
   mbd_pkg::pair_type          hs_ff;
   logic [mbd_pkg::OPOS_W-1:0] ox_ff;
   logic [mbd_pkg::OPOS_W-1:0] oy_ff;

   logic [mbd_pkg::POS_W-1:0] col_ff [mbd_pkg::MAX_LEVELS];
   logic [mbd_pkg::POS_W-1:0] row_ff [mbd_pkg::MAX_LEVELS];
   mbd_pkg::pixel_type        pend_ff [mbd_pkg::MAX_LEVELS];

   mbd_pkg::pair_type         pair_mem [mbd_pkg::MAX_WIDTH];
   mbd_pkg::pair_type         rdata_ff;

   logic                      hold_valid_ff;
   mbd_pkg::result_type       hold_ff;
   logic                      out_valid_ff;
   mbd_pkg::result_type       out_ff;
   logic                      out_last_ff;

   // ------------------------------------------------------------------------
   // Level step decode
   // ------------------------------------------------------------------------
   logic                       beyond;
   logic [mbd_pkg::LEV_W-1:0]  p_idx;
   logic [mbd_pkg::POS_W-1:0]  x, y;
   logic [mbd_pkg::DIM_W-1:0]  wp, hp, wl, hl;
   logic                       x_last, y_last;
   logic [mbd_pkg::POS_W-1:0]  col_in, row_in;
   mbd_pkg::pair_type          hs;
   logic [mbd_pkg::OPOS_W-1:0] ox, oy;
   logic                       h_ok;
   logic                       pend_wr, mem_wr, mem_rd, produce_now;
   logic                       done_lvl;
   logic [mbd_pkg::ADDR_W-1:0] addr;
   mbd_pkg::pixel_type         mean_now, mean_sum, px_req;

   always_comb begin
      beyond = lev_ff > cfg.levels;
      p_idx  = beyond ? '0 : lev_ff - mbd_pkg::LEV_W'(1);
      x      = col_ff[p_idx];
      y      = row_ff[p_idx];
      wp     = mbd_pkg::dim_at(cfg.width,  p_idx);
      hp     = mbd_pkg::dim_at(cfg.height, p_idx);
      wl     = mbd_pkg::dim_at(cfg.width,  lev_ff);
      hl     = mbd_pkg::dim_at(cfg.height, lev_ff);

      // advance the position in the stream that feeds this level
      x_last = (mbd_pkg::DIM_W'(x) + mbd_pkg::DIM_W'(1)) >= wp;
      y_last = (mbd_pkg::DIM_W'(y) + mbd_pkg::DIM_W'(1)) >= hp;
      col_in = x_last ? '0 : x + mbd_pkg::POS_W'(1);
      row_in = x_last ? (y_last ? '0 : y + mbd_pkg::POS_W'(1)) : y;

      hs          = '0;
      ox          = '0;
      oy          = '0;
      h_ok        = 1'b0;
      pend_wr     = 1'b0;
      mem_wr      = 1'b0;
      mem_rd      = 1'b0;
      produce_now = 1'b0;

      // horizontal pairing: single column reuses the pixel, odd tail drops
      if (!beyond) begin
         priority if (wp == mbd_pkg::DIM_W'(1)) begin
            for (int c = 0; c < mbd_pkg::MAX_CHANNELS; c++)
               hs[c] = {px_ff[c], 1'b0};
            h_ok = 1'b1;
         end else if (mbd_pkg::DIM_W'(x) >= (wl << 1)) begin
            h_ok = 1'b0;
         end else if (!x[0]) begin
            pend_wr = 1'b1;
         end else begin
            for (int c = 0; c < mbd_pkg::MAX_CHANNELS; c++)
               hs[c] = {1'b0, pend_ff[p_idx][c]} + {1'b0, px_ff[c]};
            ox   = x[mbd_pkg::POS_W-1:1];
            h_ok = 1'b1;
         end
      end

      // vertical pairing through the shared pair-sum memory
      if (h_ok) begin
         priority if (hp == mbd_pkg::DIM_W'(1)) begin
            produce_now = 1'b1;
         end else if (mbd_pkg::DIM_W'(y) >= (hl << 1)) begin
            produce_now = 1'b0;
         end else if (!y[0]) begin
            mem_wr = 1'b1;
         end else begin
            mem_rd = 1'b1;
            oy     = y[mbd_pkg::POS_W-1:1];
         end
      end

      addr     = base_ff + mbd_pkg::ADDR_W'(ox);
      done_lvl = !(produce_now || mem_rd);

      for (int c = 0; c < mbd_pkg::MAX_CHANNELS; c++) begin
         mean_now[c] = mbd_pkg::box_mean({hs[c], 1'b0});
         mean_sum[c] = mbd_pkg::box_mean(mbd_pkg::TOT_W'(rdata_ff[c])
                                         + mbd_pkg::TOT_W'(hs_ff[c]));
      end

      // drop channels beyond the active count at the door
      px_req[0] = req_chan.chan_0;
      px_req[1] = (cfg.channels > mbd_pkg::NCH_W'(1)) ? req_chan.chan_1 : '0;
      px_req[2] = (cfg.channels > mbd_pkg::NCH_W'(2)) ? req_chan.chan_2 : '0;
      px_req[3] = (cfg.channels > mbd_pkg::NCH_W'(3)) ? req_chan.chan_3 : '0;
   end

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   logic out_free, can_go, fire, load, push, push_last, produce_any;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign can_go   = !hold_valid_ff || out_free;

   // next state
   always_comb begin
      unique case (state_ff)
         mbd_pkg::SEQ_IDLE:
            state_in = req_chan.valid ? mbd_pkg::SEQ_LEVEL : mbd_pkg::SEQ_IDLE;
         mbd_pkg::SEQ_LEVEL: begin
            if (!can_go)
               state_in = mbd_pkg::SEQ_LEVEL;
            else if (mem_rd)
               state_in = mbd_pkg::SEQ_SUM;
            else if (done_lvl && !req_chan.valid)
               state_in = mbd_pkg::SEQ_IDLE;
            else
               state_in = mbd_pkg::SEQ_LEVEL;
         end
         mbd_pkg::SEQ_SUM:
            state_in = can_go ? mbd_pkg::SEQ_LEVEL : mbd_pkg::SEQ_SUM;
         default:
            state_in = mbd_pkg::SEQ_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      fire        = 1'b0;
      load        = 1'b0;
      push        = 1'b0;
      push_last   = 1'b0;
      produce_any = 1'b0;
      unique case (state_ff)
         mbd_pkg::SEQ_IDLE: begin
            load = req_chan.valid;
         end
         mbd_pkg::SEQ_LEVEL: begin
            fire        = can_go;
            produce_any = can_go && produce_now;
            load        = can_go && done_lvl && req_chan.valid;
            push        = can_go && hold_valid_ff && (produce_now || done_lvl);
            push_last   = done_lvl;
         end
         mbd_pkg::SEQ_SUM: begin
            fire        = can_go;
            produce_any = can_go;
            push        = can_go && hold_valid_ff;
         end
         default: ;
      endcase
   end

   assign req_chan.ready = (state_ff == mbd_pkg::SEQ_IDLE)
                        || (state_ff == mbd_pkg::SEQ_LEVEL && can_go && done_lvl);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mbd_pkg::SEQ_IDLE;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (produce_any)
            hold_valid_ff <= 1'b1;
         else if (fire && state_ff == mbd_pkg::SEQ_LEVEL && done_lvl)
            hold_valid_ff <= 1'b0;
         if (push)
            out_valid_ff <= 1'b1;
         else if (rsp_chan.ready)
            out_valid_ff <= 1'b0;
      end
   end

   // cascade position, carried pixel and read-back context
   always_ff @(posedge clock) begin
      if (load) begin
         lev_ff  <= mbd_pkg::LEV_W'(1);
         base_ff <= '0;
         px_ff   <= px_req;
      end else if (produce_any) begin
         lev_ff  <= lev_ff + mbd_pkg::LEV_W'(1);
         base_ff <= base_ff + wl[mbd_pkg::ADDR_W-1:0];
         px_ff   <= (state_ff == mbd_pkg::SEQ_SUM) ? mean_sum : mean_now;
      end
      if (fire && state_ff == mbd_pkg::SEQ_LEVEL && mem_rd) begin
         hs_ff <= hs;
         ox_ff <= ox;
         oy_ff <= oy;
      end
      if (produce_any) begin
         hold_ff.level <= lev_ff;
         if (state_ff == mbd_pkg::SEQ_SUM) begin
            hold_ff.x    <= ox_ff;
            hold_ff.y    <= oy_ff;
            hold_ff.chan <= mean_sum;
         end else begin
            hold_ff.x    <= ox;
            hold_ff.y    <= oy;
            hold_ff.chan <= mean_now;
         end
      end
      if (push) begin
         out_ff      <= hold_ff;
         out_last_ff <= push_last;
      end
   end

   // per-level stream counters; a register write restarts the frame
   always_ff @(posedge clock) begin
      if (reset || cfg.restart) begin
         for (int i = 0; i < mbd_pkg::MAX_LEVELS; i++) begin
            col_ff[i] <= '0;
            row_ff[i] <= '0;
         end
      end else if (fire && state_ff == mbd_pkg::SEQ_LEVEL && !beyond) begin
         col_ff[p_idx] <= col_in;
         row_ff[p_idx] <= row_in;
      end
   end

   // hold the even-column pixel of each level
   always_ff @(posedge clock) begin
      if (fire && state_ff == mbd_pkg::SEQ_LEVEL && pend_wr)
         pend_ff[p_idx] <= px_ff;
   end

   // pair-sum memory: one access per cycle
   always_ff @(posedge clock) begin
      if (fire && state_ff == mbd_pkg::SEQ_LEVEL && mem_wr)
         pair_mem[addr] <= hs;
      if (fire && state_ff == mbd_pkg::SEQ_LEVEL && mem_rd)
         rdata_ff <= pair_mem[addr];
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.out_level   = out_ff.level;
   assign rsp_chan.out_x       = out_ff.x;
   assign rsp_chan.out_y       = out_ff.y;
   assign rsp_chan.out_chan_0  = out_ff.chan[0];
   assign rsp_chan.out_chan_1  = out_ff.chan[1];
   assign rsp_chan.out_chan_2  = out_ff.chan[2];
   assign rsp_chan.out_chan_3  = out_ff.chan[3];
   assign rsp_chan.last_of_run = out_last_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_idle_no_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == mbd_pkg::SEQ_IDLE |-> !hold_valid_ff)
      else $error("held result while idle");

   a_sum_after_level: assert property (@(posedge clock) disable iff (reset)
      state_ff == mbd_pkg::SEQ_SUM |->
         $past(state_ff) == mbd_pkg::SEQ_LEVEL || $past(state_ff) == mbd_pkg::SEQ_SUM)
      else $error("read-back state entered without a memory read");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != mbd_pkg::SEQ_IDLE |->
         lev_ff >= mbd_pkg::LEV_W'(1) && lev_ff <= mbd_pkg::LEV_W'(mbd_pkg::MAX_LEVELS + 1))
      else $error("cascade level out of range");

   a_sum_in_levels: assert property (@(posedge clock) disable iff (reset)
      state_ff == mbd_pkg::SEQ_SUM |-> lev_ff <= cfg.levels)
      else $error("read-back beyond the configured levels");

endmodule

// File: sv/mbd_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_csr
// APB-style register file; presents clamped settings and a restart strobe.
// ----------------------------------------------------------------------------
module mbd_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [mbd_pkg::PADDR_W-1:0] paddr,
   input  logic [mbd_pkg::DATA_W-1:0]  pwdata,
   output logic [mbd_pkg::DATA_W-1:0]  prdata,
   output logic                         pready,
   output mbd_pkg::cfg_type             cfg
);

   logic [mbd_pkg::DIM_W-1:0] width_ff,    width_in;
   logic [mbd_pkg::DIM_W-1:0] height_ff,   height_in;
   logic [mbd_pkg::LEV_W-1:0] levels_ff,   levels_in;
   logic [mbd_pkg::NCH_W-1:0] channels_ff, channels_in;
   logic                      wr_en;
   logic [1:0]                reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_en   = psel & penable & pwrite & pready;

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      levels_in   = levels_ff;
      channels_in = channels_ff;
      if (wr_en) begin
         unique case (reg_idx)
            mbd_pkg::REG_WIDTH:    width_in    = pwdata[mbd_pkg::DIM_W-1:0];
            mbd_pkg::REG_HEIGHT:   height_in   = pwdata[mbd_pkg::DIM_W-1:0];
            mbd_pkg::REG_LEVELS:   levels_in   = pwdata[mbd_pkg::LEV_W-1:0];
            mbd_pkg::REG_CHANNELS: channels_in = pwdata[mbd_pkg::NCH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= mbd_pkg::DIM_W'(256);
         height_ff   <= mbd_pkg::DIM_W'(256);
         levels_ff   <= mbd_pkg::LEV_W'(8);
         channels_ff <= mbd_pkg::NCH_W'(4);
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         levels_ff   <= levels_in;
         channels_ff <= channels_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         mbd_pkg::REG_WIDTH:    prdata = mbd_pkg::DATA_W'(width_ff);
         mbd_pkg::REG_HEIGHT:   prdata = mbd_pkg::DATA_W'(height_ff);
         mbd_pkg::REG_LEVELS:   prdata = mbd_pkg::DATA_W'(levels_ff);
         mbd_pkg::REG_CHANNELS: prdata = mbd_pkg::DATA_W'(channels_ff);
         default:               prdata = '0;
      endcase
   end

   // Clamp: zero size counts as one, oversize as the store width.
   always_comb begin
      priority if (width_ff == '0)
         cfg.width = mbd_pkg::DIM_W'(1);
      else if (width_ff > mbd_pkg::DIM_W'(mbd_pkg::MAX_WIDTH))
         cfg.width = mbd_pkg::DIM_W'(mbd_pkg::MAX_WIDTH);
      else
         cfg.width = width_ff;
      priority if (height_ff == '0)
         cfg.height = mbd_pkg::DIM_W'(1);
      else if (height_ff > mbd_pkg::DIM_W'(mbd_pkg::MAX_WIDTH))
         cfg.height = mbd_pkg::DIM_W'(mbd_pkg::MAX_WIDTH);
      else
         cfg.height = height_ff;
      cfg.levels = (levels_ff > mbd_pkg::LEV_W'(mbd_pkg::MAX_LEVELS))
                   ? mbd_pkg::LEV_W'(mbd_pkg::MAX_LEVELS) : levels_ff;
      priority if (channels_ff == '0)
         cfg.channels = mbd_pkg::NCH_W'(1);
      else if (channels_ff > mbd_pkg::NCH_W'(mbd_pkg::MAX_CHANNELS))
         cfg.channels = mbd_pkg::NCH_W'(mbd_pkg::MAX_CHANNELS);
      else
         cfg.channels = channels_ff;
      cfg.restart = wr_en;
   end

endmodule

// File: dv/mipmap_box_downsampler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipmap_box_downsampler_tb
// Self-checking bench for the mip box downsampler.
// ----------------------------------------------------------------------------
// A queue of stimulus entries (pixels, register writes and drain pauses) is
// filled up front and fed to the block by a clocked driver. Every accepted
// pixel is run through a local copy of the mip cascade, which queues the mip
// pixels it should produce. A clocked monitor takes each result and checks it
// field by field against the oldest queued mip pixel. Both sides idle in
// random bursts, except in the tail of the run.
// ----------------------------------------------------------------------------
module mipmap_box_downsampler_tb;

   localparam int SETTLE_CYCLES = 48;       // idle cycles before a register write
   localparam int CALM_TAIL     = 40;       // last entries run without idling
   localparam int RANDOM_PIXELS = 150;

   typedef enum logic [1:0] {OP_PIXEL, OP_WRITE, OP_DRAIN} stim_op_type;
   typedef enum logic [1:0] {CSR_IDLE, CSR_SETUP, CSR_ACCESS} csr_state_type;

   typedef struct packed {
      stim_op_type          op;
      logic [1:0]           reg_index;
      logic [31:0]          value;
      mbd_pkg::pixel_type   pix;
   } stim_type;

   typedef struct packed {
      logic [mbd_pkg::LEV_W-1:0]  level;
      logic [mbd_pkg::OPOS_W-1:0] x;
      logic [mbd_pkg::OPOS_W-1:0] y;
      mbd_pkg::pixel_type         chan;
      logic                       last;
   } mip_pixel_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [mbd_pkg::PADDR_W-1:0] csr_paddr;
   logic [mbd_pkg::DATA_W-1:0]  csr_pwdata, csr_prdata;

   mbd_req_if req_bus ();
   mbd_rsp_if rsp_bus ();

   mipmap_box_downsampler dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (csr_psel),
      .penable  (csr_penable),
      .pwrite   (csr_pwrite),
      .paddr    (csr_paddr),
      .pwdata   (csr_pwdata),
      .prdata   (csr_prdata),
      .pready   (csr_pready)
   );

   // Stimulus and expectations.
   stim_type      stim_q[$];
   mip_pixel_type expected_mips[$];
   int            error_count = 0;

   // Shadow of the block: registers, pair sums, pending pixels, positions.
   logic [12:0] width_reg, height_reg;
   logic [3:0]  levels_reg;
   logic [2:0]  channels_reg;
   logic [8:0]  pair_sums [0:mbd_pkg::MAX_WIDTH-1][0:3];
   logic [7:0]  pend_pix  [0:mbd_pkg::MAX_LEVELS-1][0:3];
   int          col_pos   [0:mbd_pkg::MAX_LEVELS];
   int          row_pos   [0:mbd_pkg::MAX_LEVELS];

   function automatic bit calm();
      return stim_q.size() < CALM_TAIL;
   endfunction

   task automatic report(input string what);
      error_count++;
      $display("ERROR @%0t: %s", $realtime, what);
   endtask

   task automatic clear_positions();
      for (int i = 0; i <= mbd_pkg::MAX_LEVELS; i++) begin
         col_pos[i] = 0;
         row_pos[i] = 0;
      end
   endtask

   task automatic apply_write(input logic [1:0] idx, input logic [31:0] v);
      case (idx)
         mbd_pkg::REG_WIDTH:    width_reg    = v[12:0];
         mbd_pkg::REG_HEIGHT:   height_reg   = v[12:0];
         mbd_pkg::REG_LEVELS:   levels_reg   = v[3:0];
         mbd_pkg::REG_CHANNELS: channels_reg = v[2:0];
         default: ;
      endcase
      clear_positions();
   endtask

   // Walk one level-0 pixel down the cascade and queue the mip pixels it
   // completes; the last one of the run carries the last flag.
   task automatic compute_mips(input mbd_pkg::pixel_type pin);
      int wd[0:mbd_pkg::MAX_LEVELS];
      int ht[0:mbd_pkg::MAX_LEVELS];
      int px[4], hs[4], tot[4];
      int nlev, nch, base, p, wp, hp, x, y, ox, oy, addr, count;
      bit done, ready;
      mip_pixel_type run[mbd_pkg::MAX_LEVELS];
      nlev  = (levels_reg > mbd_pkg::MAX_LEVELS) ? mbd_pkg::MAX_LEVELS : levels_reg;
      nch   = (channels_reg == 0) ? 1 : channels_reg;
      if (nch > mbd_pkg::MAX_CHANNELS) nch = mbd_pkg::MAX_CHANNELS;
      wd[0] = (width_reg == 0) ? 1 :
              (width_reg > mbd_pkg::MAX_WIDTH) ? mbd_pkg::MAX_WIDTH : width_reg;
      ht[0] = (height_reg == 0) ? 1 :
              (height_reg > mbd_pkg::MAX_WIDTH) ? mbd_pkg::MAX_WIDTH : height_reg;
      for (int l = 1; l <= mbd_pkg::MAX_LEVELS; l++) begin
         wd[l] = (wd[l-1] >> 1 == 0) ? 1 : wd[l-1] >> 1;
         ht[l] = (ht[l-1] >> 1 == 0) ? 1 : ht[l-1] >> 1;
      end
      for (int c = 0; c < 4; c++) px[c] = (c < nch) ? pin[c] : 0;
      base  = 0;
      count = 0;
      done  = 0;
      for (int lev = 1; lev <= nlev + 1 && !done; lev++) begin
         p  = lev - 1;
         wp = wd[p];
         hp = ht[p];
         x  = col_pos[p];
         y  = row_pos[p];
         // advance the stream that feeds this level
         if (x + 1 >= wp) begin
            col_pos[p] = 0;
            row_pos[p] = (y + 1 >= hp) ? 0 : y + 1;
         end else begin
            col_pos[p] = x + 1;
         end
         if (lev > nlev) begin
            done = 1;
            continue;
         end
         // horizontal pair: width 1 reuses the pixel, odd last column drops
         if (wp == 1) begin
            for (int c = 0; c < 4; c++) hs[c] = 2 * px[c];
            ox = 0;
         end else begin
            if (x >= 2 * wd[lev]) begin
               done = 1;
               continue;
            end
            ox = x >> 1;
            if (x % 2 == 0) begin
               for (int c = 0; c < 4; c++) pend_pix[p][c] = mbd_pkg::CH_W'(px[c]);
               done = 1;
               continue;
            end
            for (int c = 0; c < 4; c++) hs[c] = pend_pix[p][c] + px[c];
         end
         // vertical pair through the shared store
         addr = (base + ox) % mbd_pkg::MAX_WIDTH;
         base += wd[lev];
         oy = 0;
         ready = 0;
         if (hp == 1) begin
            for (int c = 0; c < 4; c++) tot[c] = 2 * hs[c];
            ready = 1;
         end else if (y < 2 * ht[lev]) begin
            oy = y >> 1;
            if (y % 2 == 0) begin
               for (int c = 0; c < 4; c++) pair_sums[addr][c] = mbd_pkg::HS_W'(hs[c]);
            end else begin
               for (int c = 0; c < 4; c++) tot[c] = pair_sums[addr][c] + hs[c];
               ready = 1;
            end
         end
         if (!ready) begin
            done = 1;
            continue;
         end
         for (int c = 0; c < 4; c++) px[c] = (c < nch) ? ((tot[c] + 2) >> 2) & 8'hFF : 0;
         run[count].level = mbd_pkg::LEV_W'(lev);
         run[count].x     = mbd_pkg::OPOS_W'(ox);
         run[count].y     = mbd_pkg::OPOS_W'(oy);
         for (int c = 0; c < 4; c++) run[count].chan[c] = mbd_pkg::CH_W'(px[c]);
         run[count].last  = 1'b0;
         count++;
      end
      if (count > 0) run[count-1].last = 1'b1;
      for (int i = 0; i < count; i++) expected_mips = {expected_mips, run[i]};
   endtask

   // Clock and the single reset pulse.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Driver: present pixels, drain before writes, run the setup and access write.
   // ------------------------------------------------------------------------
   csr_state_type csr_state;
   int            gap_left;
   int            quiet_cycles;

   always @(posedge clock) begin : drive_pixels
      stim_type nxt;
      if (reset) begin
         req_bus.valid  <= 1'b0;
         req_bus.chan_0 <= '0;
         req_bus.chan_1 <= '0;
         req_bus.chan_2 <= '0;
         req_bus.chan_3 <= '0;
         csr_psel       <= 1'b0;
         csr_penable    <= 1'b0;
         csr_pwrite     <= 1'b0;
         csr_paddr      <= '0;
         csr_pwdata     <= '0;
         csr_state      <= CSR_IDLE;
         gap_left       <= 0;
         quiet_cycles    = 0;
         width_reg       = 13'd256;
         height_reg      = 13'd256;
         levels_reg      = 4'd8;
         channels_reg    = 3'd4;
         for (int l = 0; l < mbd_pkg::MAX_LEVELS; l++)
            for (int c = 0; c < 4; c++) pend_pix[l][c] = '0;
         clear_positions();
      end else begin
         // predict every pixel taken at this edge
         if (req_bus.valid && req_bus.ready)
            compute_mips({req_bus.chan_3, req_bus.chan_2, req_bus.chan_1, req_bus.chan_0});
         // count cycles with nothing in flight on either side
         if (!req_bus.valid && expected_mips.size() == 0) quiet_cycles++;
         else quiet_cycles = 0;

         case (csr_state)
            CSR_SETUP: begin
               csr_penable <= 1'b1;
               csr_state   <= CSR_ACCESS;
            end
            CSR_ACCESS: begin
               // the register takes the write at this edge
               if (csr_pready) begin
                  apply_write(csr_paddr[3:2], csr_pwdata);
                  csr_psel    <= 1'b0;
                  csr_penable <= 1'b0;
                  csr_state   <= CSR_IDLE;
               end
            end
            default: begin
               // hold the item while the block has not taken it
               if (!(req_bus.valid && !req_bus.ready)) begin
                  if (gap_left > 0) begin
                     gap_left      <= gap_left - 1;
                     req_bus.valid <= 1'b0;
                  end else if (stim_q.size() == 0) begin
                     req_bus.valid <= 1'b0;
                  end else if (stim_q[0].op == OP_PIXEL) begin
                     if (!calm() && $urandom_range(0, 5) == 0) begin
                        gap_left      <= $urandom_range(1, 16) - 1;
                        req_bus.valid <= 1'b0;
                     end else begin
                        nxt = stim_q.pop_front();
                        req_bus.valid  <= 1'b1;
                        req_bus.chan_0 <= nxt.pix[0];
                        req_bus.chan_1 <= nxt.pix[1];
                        req_bus.chan_2 <= nxt.pix[2];
                        req_bus.chan_3 <= nxt.pix[3];
                     end
                  end else begin
                     // drain fully, then let the block settle
                     req_bus.valid <= 1'b0;
                     if (quiet_cycles >= SETTLE_CYCLES) begin
                        nxt = stim_q.pop_front();
                        quiet_cycles = 0;
                        if (nxt.op == OP_WRITE) begin
                           csr_psel   <= 1'b1;
                           csr_pwrite <= 1'b1;
                           csr_paddr  <= {nxt.reg_index, 2'b00};
                           csr_pwdata <= nxt.value;
                           csr_state  <= CSR_SETUP;
                        end
                     end
                  end
               end
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: stall at random, check each result against the oldest mip pixel.
   // ------------------------------------------------------------------------
   int stall_left;

   always @(posedge clock) begin : check_mips
      mip_pixel_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_mips.size() == 0) begin
               report($sformatf("unexpected mip pixel L%0d (%0d,%0d)",
                      rsp_bus.out_level, rsp_bus.out_x, rsp_bus.out_y));
            end else begin
               want = expected_mips.pop_front();
               if (rsp_bus.out_level !== want.level)
                  report($sformatf("level %0d, want %0d", rsp_bus.out_level, want.level));
               if (rsp_bus.out_x !== want.x)
                  report($sformatf("x %0d, want %0d", rsp_bus.out_x, want.x));
               if (rsp_bus.out_y !== want.y)
                  report($sformatf("y %0d, want %0d", rsp_bus.out_y, want.y));
               if (rsp_bus.out_chan_0 !== want.chan[0])
                  report($sformatf("chan 0 %0d, want %0d", rsp_bus.out_chan_0, want.chan[0]));
               if (rsp_bus.out_chan_1 !== want.chan[1])
                  report($sformatf("chan 1 %0d, want %0d", rsp_bus.out_chan_1, want.chan[1]));
               if (rsp_bus.out_chan_2 !== want.chan[2])
                  report($sformatf("chan 2 %0d, want %0d", rsp_bus.out_chan_2, want.chan[2]));
               if (rsp_bus.out_chan_3 !== want.chan[3])
                  report($sformatf("chan 3 %0d, want %0d", rsp_bus.out_chan_3, want.chan[3]));
               if (rsp_bus.last_of_run !== want.last)
                  report($sformatf("last_of_run %0b, want %0b", rsp_bus.last_of_run, want.last));
            end
         end
         if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            rsp_bus.ready <= 1'b0;
         end else if (!calm() && $urandom_range(0, 7) == 0) begin
            stall_left    <= $urandom_range(1, 16) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus build and end of run.
   // ------------------------------------------------------------------------
   task automatic add_write(input logic [1:0] idx, input logic [31:0] v);
      stim_type s;
      s = '0;
      s.op = OP_WRITE;
      s.reg_index = idx;
      s.value = v;
      stim_q = {stim_q, s};
   endtask

   task automatic add_pixel(input mbd_pkg::pixel_type p);
      stim_type s;
      s = '0;
      s.op = OP_PIXEL;
      s.pix = p;
      stim_q = {stim_q, s};
   endtask

   function automatic mbd_pkg::pixel_type rand_pixel();
      mbd_pkg::pixel_type p;
      case ($urandom_range(0, 9))
         0:       p = '0;
         1:       p = '1;
         default: p = $urandom();
      endcase
      return p;
   endfunction

   initial begin : run_test
      stim_type s;
      int sent, w, h, n;
      // directed: 4x4 frame, two levels, all channels, extreme values
      add_write(mbd_pkg::REG_WIDTH, 4);
      add_write(mbd_pkg::REG_HEIGHT, 4);
      add_write(mbd_pkg::REG_LEVELS, 2);
      add_write(mbd_pkg::REG_CHANNELS, 4);
      for (int i = 0; i < 16; i++)
         add_pixel((i % 3 == 0) ? '1 : (i % 3 == 1) ? '0 : 32'hAA55_F00F);
      // drain once before going on
      s = '0;
      s.op = OP_DRAIN;
      stim_q = {stim_q, s};
      // zero size and too many levels: a 1x1 image feeds all twelve levels;
      // zero channels counts as one
      add_write(mbd_pkg::REG_WIDTH, 0);
      add_write(mbd_pkg::REG_HEIGHT, 1);
      add_write(mbd_pkg::REG_LEVELS, 15);
      add_write(mbd_pkg::REG_CHANNELS, 0);
      add_pixel('1);
      add_pixel(32'h0102_03FE);
      add_pixel('0);
      // oversize width, odd height, more channels than exist, no levels then one
      add_write(mbd_pkg::REG_WIDTH, 13'h1FFF);
      add_write(mbd_pkg::REG_HEIGHT, 3);
      add_write(mbd_pkg::REG_CHANNELS, 7);
      add_write(mbd_pkg::REG_LEVELS, 0);
      add_pixel('1);
      add_pixel('1);
      add_write(mbd_pkg::REG_LEVELS, 1);
      for (int i = 0; i < 4; i++) add_pixel(rand_pixel());

      // random phases, each one or two frames of a random shape plus up to three pixels, or 40 pixels of a large one
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         if ($urandom_range(0, 7) == 0) begin
            w = $urandom_range(0, 8191);
            h = $urandom_range(1, 2);
         end else begin
            w = $urandom_range(0, 12);
            h = $urandom_range(0, 12);
         end
         add_write(mbd_pkg::REG_WIDTH, w);
         add_write(mbd_pkg::REG_HEIGHT, h);
         if ($urandom_range(0, 1)) add_write(mbd_pkg::REG_LEVELS, $urandom_range(0, 15));
         if ($urandom_range(0, 1)) add_write(mbd_pkg::REG_CHANNELS, $urandom_range(0, 7));
         if (w == 0) w = 1;
         if (h == 0) h = 1;
         n = (w * h > 60) ? 40 : w * h * $urandom_range(1, 2) + $urandom_range(0, 3);
         for (int i = 0; i < n; i++) add_pixel(rand_pixel());
         sent += n;
      end

      // wait for the queue to empty and every mip pixel to arrive
      @(negedge reset);
      do @(posedge clock);
      while (stim_q.size() != 0 || req_bus.valid || csr_state != CSR_IDLE ||
             expected_mips.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_mips.size() != 0)
         report($sformatf("%0d mip pixels never arrived", expected_mips.size()));
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #4_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

// File: sim.f
sv/mbd_pkg.sv
sv/mbd_req_if.sv
sv/mbd_rsp_if.sv
sv/mbd_csr.sv
sv/mipmap_box_downsampler.sv
dv/mipmap_box_downsampler_tb.sv
